// ===== design/rgbc_pkg.sv =====
// Shared constants and types for the RGBC to HSV converter.
package rgbc_pkg;

    // Widths of the raw counts and of the fixed-point results.
    localparam int RAW_W = 16;
    localparam int Q_W = 17;
    localparam int HUE_W = 15;

    // Default depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // Q1.16 one and the hue constants in Q9.6 degrees.
    localparam logic [Q_W-1:0] Q16_ONE = 17'd65536;
    localparam int HUE_SEXTANT = 3840;
    localparam int HUE_FULL = 23040;

    // Sextant selector: which channel holds the maximum.
    localparam logic [1:0] SEL_RED = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE = 2'd2;

    // One classified sample as it crosses the queue.
    typedef struct packed {
        logic            zero;
        logic [RAW_W-1:0] red;
        logic [RAW_W-1:0] green;
        logic [RAW_W-1:0] blue;
        logic [RAW_W-1:0] clear;
    } t_sample;

endpackage

// ===== design/rgbc_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, rounding done by the caller.
module rgbc_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 18,
    parameter int Q_BITS = 18,
    parameter int TAG_W = 8
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic [Q_BITS-1:0] o_quot,
    output logic [TAG_W-1:0] o_tag
);

    // Bits of the numerator above the quotient width seed the remainder; the
    // caller guarantees they are below the divisor.
    localparam int HI_W = NUM_W - Q_BITS;

    // Per-stage registers: partial remainder, remaining numerator bits, quotient.
    logic [DEN_W:0]       r_rem  [1:Q_BITS];
    logic [NUM_W-1:0]     r_num  [1:Q_BITS];
    logic [DEN_W-1:0]     r_den  [1:Q_BITS];
    logic [Q_BITS-1:0]    r_quot [1:Q_BITS];
    logic [TAG_W-1:0]     r_tag  [1:Q_BITS];

    // One stage per quotient bit; stages advance together on enable.
    for (genvar s = 0; s < Q_BITS; s++) begin : g_stage
        logic [DEN_W:0]    rem_in;
        logic [NUM_W-1:0]  num_in;
        logic [DEN_W-1:0]  den_in;
        logic [Q_BITS-1:0] quot_in;
        logic [TAG_W-1:0]  tag_in;
        logic [DEN_W+1:0]  trial;
        logic [DEN_W+1:0]  shifted;

        // The first stage takes the request, later stages the previous stage.
        if (s == 0) begin : g_first
            assign rem_in  = (DEN_W + 1)'(i_num[NUM_W-1 -: HI_W]);
            assign num_in  = i_num << HI_W;
            assign den_in  = i_den;
            assign quot_in = '0;
            assign tag_in  = i_tag;
        end else begin : g_next
            assign rem_in  = r_rem[s];
            assign num_in  = r_num[s];
            assign den_in  = r_den[s];
            assign quot_in = r_quot[s];
            assign tag_in  = r_tag[s];
        end

        always_comb begin
            shifted = {rem_in, num_in[NUM_W-1]};
            trial   = shifted - (DEN_W + 2)'(den_in);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!trial[DEN_W+1]) begin
                    r_rem[s+1]  <= trial[DEN_W:0];
                    r_quot[s+1] <= {quot_in[Q_BITS-2:0], 1'b1};
                end else begin
                    r_rem[s+1]  <= shifted[DEN_W:0];
                    r_quot[s+1] <= {quot_in[Q_BITS-2:0], 1'b0};
                end
                r_num[s+1] <= num_in << 1;
                r_den[s+1] <= den_in;
                r_tag[s+1] <= tag_in;
            end
        end
    end

    assign o_quot = r_quot[Q_BITS];
    assign o_tag  = r_tag[Q_BITS];

endmodule

// ===== design/rgbc_front.sv =====
// Front part: accepts raw samples, flags the zero-clear case and queues them.
module rgbc_front #(
    parameter int DEPTH = rgbc_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [rgbc_pkg::RAW_W-1:0] i_red_raw,
    input  logic [rgbc_pkg::RAW_W-1:0] i_green_raw,
    input  logic [rgbc_pkg::RAW_W-1:0] i_blue_raw,
    input  logic [rgbc_pkg::RAW_W-1:0] i_clear_raw,
    output logic                       o_valid,
    input  logic                       i_take,
    output rgbc_pkg::t_sample          o_sample
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    rgbc_pkg::t_sample r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd, n_wr, n_rd;
    logic [PTR_W:0]    r_cnt, n_cnt;
    logic              push, pop;

    assign o_stall  = (r_cnt == (PTR_W + 1)'(DEPTH));
    assign push     = i_valid && !o_stall;
    assign pop      = i_take && (r_cnt != '0);
    assign o_valid  = (r_cnt != '0);
    assign o_sample = r_mem[r_rd];

    // Pointer advance with wrap at the queue depth.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        n_cnt = r_cnt + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Classify and store the sample.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= '{zero: (i_clear_raw == '0), red: i_red_raw,
                             green: i_green_raw, blue: i_blue_raw,
                             clear: i_clear_raw};
        end
    end

endmodule

// ===== design/rgbc_back.sv =====
// Back part: normalize, find max/min, then divide for saturation and hue.
module rgbc_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_take,
    input  rgbc_pkg::t_sample          i_sample,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [rgbc_pkg::HUE_W-1:0] o_hue,
    output logic [rgbc_pkg::Q_W-1:0]   o_saturation,
    output logic [rgbc_pkg::Q_W-1:0]   o_brightness
);

    localparam int QW = rgbc_pkg::Q_W;
    // Stage latencies: normalize divider, one compare stage, second divider.
    localparam int D1 = 18;
    localparam int D2 = 18;
    localparam int LAT = D1 + 1 + D2 + 1;

    // Whole pipeline moves when the output register is free.
    logic en;
    logic [LAT-1:0] r_vld;
    assign en     = !(o_valid && i_stall);
    assign o_take = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Normalize: q = floor((raw*131072 + clear) / (2*clear)), clear nonzero.
    logic [33:0] nr, ng, nb;
    logic [17:0] dc;
    logic [17:0] qr, qg, qb;
    logic        zero_d;
    logic [7:0]  tag_in, tag_r, tag_g, tag_b;
    assign dc = (i_sample.clear == '0) ? 18'd2 : {1'b0, i_sample.clear, 1'b0};
    assign nr = {1'b0, i_sample.red, 17'd0} + 34'(i_sample.clear);
    assign ng = {1'b0, i_sample.green, 17'd0} + 34'(i_sample.clear);
    assign nb = {1'b0, i_sample.blue, 17'd0} + 34'(i_sample.clear);
    assign tag_in = {7'd0, i_sample.zero};

    // The quotient can exceed 18 bits; seed bits above must be below divisor,
    // so pre-clamp: raw >= clear means the result clamps to one.
    logic [33:0] nr_c, ng_c, nb_c;
    logic [33:0] one_num;
    assign one_num = {1'b0, i_sample.clear, 17'd0};
    assign nr_c = (i_sample.red >= i_sample.clear) ? one_num : nr;
    assign ng_c = (i_sample.green >= i_sample.clear) ? one_num : ng;
    assign nb_c = (i_sample.blue >= i_sample.clear) ? one_num : nb;

    rgbc_div #(.NUM_W(34), .DEN_W(18), .Q_BITS(18), .TAG_W(8)) u_div_r (
        .i_clk(i_clk), .i_en(en), .i_num(nr_c), .i_den(dc), .i_tag(tag_in),
        .o_quot(qr), .o_tag(tag_r));
    rgbc_div #(.NUM_W(34), .DEN_W(18), .Q_BITS(18), .TAG_W(8)) u_div_g (
        .i_clk(i_clk), .i_en(en), .i_num(ng_c), .i_den(dc), .i_tag(tag_in),
        .o_quot(qg), .o_tag(tag_g));
    rgbc_div #(.NUM_W(34), .DEN_W(18), .Q_BITS(18), .TAG_W(8)) u_div_b (
        .i_clk(i_clk), .i_en(en), .i_num(nb_c), .i_den(dc), .i_tag(tag_in),
        .o_quot(qb), .o_tag(tag_b));
    assign zero_d = tag_r[0];

    // Clamp, max, min and the sextant numerator.
    logic [QW-1:0] r, g, b, mx, mn, dl;
    logic [1:0]    sel;
    logic signed [18:0] diff;
    always_comb begin
        r = (qr > 18'(rgbc_pkg::Q16_ONE)) ? rgbc_pkg::Q16_ONE : qr[QW-1:0];
        g = (qg > 18'(rgbc_pkg::Q16_ONE)) ? rgbc_pkg::Q16_ONE : qg[QW-1:0];
        b = (qb > 18'(rgbc_pkg::Q16_ONE)) ? rgbc_pkg::Q16_ONE : qb[QW-1:0];
        mx = r; sel = rgbc_pkg::SEL_RED;
        if (g > mx) begin mx = g; sel = rgbc_pkg::SEL_GREEN; end
        if (b > mx) begin mx = b; sel = rgbc_pkg::SEL_BLUE; end
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        dl = mx - mn;
        unique case (sel)
            rgbc_pkg::SEL_RED:   diff = 19'(signed'({2'b0, g})) - 19'(signed'({2'b0, b}));
            rgbc_pkg::SEL_GREEN: diff = 19'(signed'({2'b0, b})) - 19'(signed'({2'b0, r}));
            default:             diff = 19'(signed'({2'b0, r})) - 19'(signed'({2'b0, g}));
        endcase
    end

    // Register the compare results before the second division.
    logic [QW-1:0]      r_mx, r_dl;
    logic signed [18:0] r_diff;
    logic [1:0]         r_sel;
    logic               r_zero;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mx   <= mx;
            r_dl   <= dl;
            r_diff <= diff;
            r_sel  <= sel;
            r_zero <= zero_d;
        end
    end

    // Hue numerator: 3840*diff + 3840*k*delta, wrapped by 23040*delta.
    // diff*3840 is a 19x12 constant product; 3840*k*delta is a constant product too.
    logic signed [36:0] hnum;
    logic [35:0]        hnum_u;
    logic [35:0]        hn2;
    logic [18:0]        hden;
    always_comb begin
        hnum = 37'(r_diff) * 37'sd3840;
        unique case (r_sel)
            rgbc_pkg::SEL_RED:   hnum = hnum;
            rgbc_pkg::SEL_GREEN: hnum = hnum + 37'(signed'({1'b0, r_dl})) * 37'sd7680;
            default:             hnum = hnum + 37'(signed'({1'b0, r_dl})) * 37'sd15360;
        endcase
        if (hnum < 0) hnum = hnum + 37'(signed'({1'b0, r_dl})) * 37'sd23040;
        if (hnum < 0) hnum = '0;
        hnum_u = hnum[35:0];
        hn2  = (hnum_u << 1) + 36'(r_dl);
        hden = (r_dl == '0) ? 19'd2 : {1'b0, r_dl, 1'b0};
    end

    // Saturation: floor((delta*131072 + max) / (2*max)), result at most 65536.
    logic [35:0] sn;
    logic [18:0] sd;
    assign sn = {2'b0, r_dl, 17'd0} + 36'(r_mx);
    assign sd = (r_mx == '0) ? 19'd2 : {1'b0, r_mx, 1'b0};

    logic [17:0] sq, hq;
    logic [QW+1:0] tag2_in, tag_s, tag_h;
    assign tag2_in = {r_zero, (r_mx == '0), r_mx};

    rgbc_div #(.NUM_W(36), .DEN_W(19), .Q_BITS(18), .TAG_W(QW + 2)) u_div_s (
        .i_clk(i_clk), .i_en(en), .i_num(sn), .i_den(sd), .i_tag(tag2_in),
        .o_quot(sq), .o_tag(tag_s));

    logic [QW-1:0] dl_z;
    assign dl_z = r_dl;
    rgbc_div #(.NUM_W(36), .DEN_W(19), .Q_BITS(18), .TAG_W(QW + 2)) u_div_h (
        .i_clk(i_clk), .i_en(en), .i_num(hn2), .i_den(hden),
        .i_tag({1'b0, (dl_z == '0), dl_z}), .o_quot(hq), .o_tag(tag_h));

    // Output register with the zero-clear, zero-max and zero-delta cases.
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (tag_s[QW+1]) begin
                o_hue        <= '0;
                o_saturation <= '0;
                o_brightness <= '0;
            end else begin
                o_brightness <= tag_s[QW-1:0];
                o_saturation <= tag_s[QW] ? '0 : sq[QW-1:0];
                o_hue <= (tag_h[QW] || hq >= 18'(rgbc_pkg::HUE_FULL)) ? '0
                         : hq[rgbc_pkg::HUE_W-1:0];
            end
        end
    end

endmodule

// ===== design/rgbc_to_hsv_converter.sv =====
// Top level of the RGBC to HSV converter: front queue and back pipeline.
//
// Input channel: i_valid with i_red_raw, i_green_raw, i_blue_raw and
// i_clear_raw; a request is taken when i_valid is high and o_stall is low.
// Output channel: o_valid with o_hue (Q9.6 degrees), o_saturation and
// o_brightness (Q1.16); a request leaves when o_valid is high and i_stall
// is low.
// From acceptance to o_valid a sample passes the front queue, 18 stages of
// the normalizing dividers, one compare stage, 18 stages of the saturation
// and hue dividers and the output register. Throughput is one sample per
// cycle while the receiver does not stall; the one-bit-per-stage dividers
// set the latency.
// When the receiver stalls, the back pipeline freezes with its result held
// and the front queue keeps taking samples until it is full.
// Reset empties the queue and clears all pipeline valid bits.
module rgbc_to_hsv_converter #(
    parameter int QUEUE_DEPTH = rgbc_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [rgbc_pkg::RAW_W-1:0] i_red_raw,
    input  logic [rgbc_pkg::RAW_W-1:0] i_green_raw,
    input  logic [rgbc_pkg::RAW_W-1:0] i_blue_raw,
    input  logic [rgbc_pkg::RAW_W-1:0] i_clear_raw,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [rgbc_pkg::HUE_W-1:0] o_hue,
    output logic [rgbc_pkg::Q_W-1:0]   o_saturation,
    output logic [rgbc_pkg::Q_W-1:0]   o_brightness
);

    logic              q_valid, q_take;
    rgbc_pkg::t_sample q_sample;

    rgbc_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_red_raw(i_red_raw), .i_green_raw(i_green_raw),
        .i_blue_raw(i_blue_raw), .i_clear_raw(i_clear_raw),
        .o_valid(q_valid), .i_take(q_take), .o_sample(q_sample));

    rgbc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_take(q_take),
        .i_sample(q_sample), .o_valid(o_valid), .i_stall(i_stall),
        .o_hue(o_hue), .o_saturation(o_saturation), .o_brightness(o_brightness));

    // Results stay in range.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue < 15'd23040 && o_brightness <= rgbc_pkg::Q16_ONE))
        else $error("result out of range");

    // Saturation never exceeds one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_saturation <= rgbc_pkg::Q16_ONE)
        else $error("saturation above one");

    // Zero brightness implies zero saturation and hue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_brightness == '0) |-> (o_saturation == '0 && o_hue == '0))
        else $error("dark pixel with color");

endmodule

// ===== dv/testbench.sv =====
// Testbench for the RGBC to HSV converter with a self-checking scoreboard.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Expected HSV triple for one accepted sample.
    typedef struct packed {
        logic [rgbc_pkg::HUE_W-1:0] hue;
        logic [rgbc_pkg::Q_W-1:0]   sat;
        logic [rgbc_pkg::Q_W-1:0]   val;
    } t_hsv;

    // Scoreboard: converts accepted samples and checks the results in order.
    class hsv_scoreboard;
        t_hsv pending[$];
        int   errors;
        int   matched;

        function logic [rgbc_pkg::Q_W-1:0] norm_channel(logic [63:0] raw,
                                                        logic [63:0] clr);
            logic [63:0] q;
            q = (raw * 64'd131072 + clr) / (64'd2 * clr);
            if (q > 64'd65536) q = 64'd65536;
            return q[rgbc_pkg::Q_W-1:0];
        endfunction

        function t_hsv convert(logic [15:0] rr, logic [15:0] gr, logic [15:0] br,
                               logic [15:0] cr);
            t_hsv o;
            logic [63:0] r, g, b, mx, mn, dl, h;
            longint diff, k, num;
            o = '0;
            if (cr == 16'd0) return o;
            r = 64'(norm_channel(64'(rr), 64'(cr)));
            g = 64'(norm_channel(64'(gr), 64'(cr)));
            b = 64'(norm_channel(64'(br), 64'(cr)));
            mx = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            mn = r;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            dl = mx - mn;
            if (mx != 0) o.sat = rgbc_pkg::Q_W'((dl * 64'd131072 + mx) / (64'd2 * mx));
            if (dl != 0) begin
                // Ties go to red first, then green.
                if (mx == r) begin
                    diff = longint'(g) - longint'(b);
                    k = 0;
                end else if (mx == g) begin
                    diff = longint'(b) - longint'(r);
                    k = 2;
                end else begin
                    diff = longint'(r) - longint'(g);
                    k = 4;
                end
                num = rgbc_pkg::HUE_SEXTANT * diff
                      + rgbc_pkg::HUE_SEXTANT * k * longint'(dl);
                if (num < 0) num += rgbc_pkg::HUE_FULL * longint'(dl);
                if (num < 0) num = 0;
                h = (64'(num) * 64'd2 + dl) / (64'd2 * dl);
                if (h >= rgbc_pkg::HUE_FULL) h = 0;
                o.hue = h[rgbc_pkg::HUE_W-1:0];
            end
            o.val = mx[rgbc_pkg::Q_W-1:0];
            return o;
        endfunction

        function void note_sample(logic [15:0] rr, logic [15:0] gr, logic [15:0] br,
                                  logic [15:0] cr);
            pending.push_back(convert(rr, gr, br, cr));
        endfunction

        function void check_result(logic [rgbc_pkg::HUE_W-1:0] hue,
                                   logic [rgbc_pkg::Q_W-1:0] sat,
                                   logic [rgbc_pkg::Q_W-1:0] val);
            t_hsv e;
            if (pending.size() == 0) begin
                $error("unexpected result hue=%0d sat=%0d val=%0d", hue, sat, val);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (hue !== e.hue) begin
                $error("hue expected %0d actual %0d", e.hue, hue);
                errors++;
            end
            if (sat !== e.sat) begin
                $error("saturation expected %0d actual %0d", e.sat, sat);
                errors++;
            end
            if (val !== e.val) begin
                $error("brightness expected %0d actual %0d", e.val, val);
                errors++;
            end
            matched++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid;
    logic [rgbc_pkg::RAW_W-1:0] i_red_raw = '0, i_green_raw = '0;
    logic [rgbc_pkg::RAW_W-1:0] i_blue_raw = '0, i_clear_raw = '0;
    logic [rgbc_pkg::HUE_W-1:0] o_hue;
    logic [rgbc_pkg::Q_W-1:0]   o_saturation, o_brightness;

    hsv_scoreboard sb = new();
    int  cycles = 0;
    int  sent = 0;
    bit  hold_off = 1'b0;
    bit  hold_armed = 1'b0;

    localparam int CYCLE_LIMIT = 400000;

    rgbc_to_hsv_converter u_top (.*);

    always #1 i_clk = ~i_clk;

    // Watchdog on the cycle count.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** rgbc_to_hsv_converter: FAILED **");
            $finish;
        end
    end

    // Note accepted requests on the input side and check them on the output side.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            sb.note_sample(i_red_raw, i_green_raw, i_blue_raw, i_clear_raw);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_hue, o_saturation, o_brightness);
    end

    // Receiver stall pattern, with one long hold-off counted here.
    initial begin
        int mode;
        int n;
        @(posedge i_rst_n);
        while (1) begin
            @(negedge i_clk);
            if (hold_off) begin
                i_stall <= 1'b1;
                for (n = 0; n < 200; n++) @(negedge i_clk);
                hold_off = 1'b0;
            end
            mode = (cycles / 300) % 3;
            if (mode == 0) i_stall <= 1'b0;
            else if (mode == 1) i_stall <= ($urandom_range(0, 3) == 0);
            else i_stall <= ($urandom_range(0, 1) == 0);
        end
    end

    // Offer one request and hold it until accepted.
    task automatic send_sample(logic [15:0] rr, logic [15:0] gr, logic [15:0] br,
                               logic [15:0] cr);
        i_red_raw <= rr;
        i_green_raw <= gr;
        i_blue_raw <= br;
        i_clear_raw <= cr;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_gap(int n);
        i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Random sample shaped toward interesting regions.
    task automatic send_random();
        logic [15:0] r, g, b, c;
        int kind;
        kind = $urandom_range(0, 9);
        r = 16'($urandom);
        g = 16'($urandom);
        b = 16'($urandom);
        c = 16'($urandom);
        case (kind)
            0: c = 16'd0;
            1: c = 16'($urandom_range(1, 4));
            2: begin
                c = 16'($urandom_range(1, 65535));
                r = 16'($urandom_range(0, c));
                g = r;
                b = 16'($urandom_range(0, c));
            end
            3: begin
                g = r;
                b = r;
            end
            4: begin
                c = 16'($urandom_range(1000, 65535));
                r = 16'($urandom_range(0, c));
                g = 16'($urandom_range(0, c));
                b = 16'($urandom_range(0, c));
            end
            5: begin
                r = 16'($urandom_range(0, 3));
                g = 16'($urandom_range(0, 3));
                b = 16'($urandom_range(0, 3));
            end
            default: ;
        endcase
        send_sample(r, g, b, c);
    endtask

    initial begin
        int i;
        int burst;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed corners: zero clear, zero max, ties, clamping, each sextant.
        send_sample(16'd0, 16'd0, 16'd0, 16'd0);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        send_sample(16'd0, 16'd0, 16'd0, 16'd1);
        send_sample(16'd0, 16'd0, 16'd0, 16'hFFFF);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'hFFFF, 16'd0, 16'd0, 16'd1);
        send_sample(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        send_sample(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        send_sample(16'd100, 16'd100, 16'd0, 16'd200);
        send_sample(16'd0, 16'd100, 16'd100, 16'd200);
        send_sample(16'd100, 16'd0, 16'd100, 16'd200);
        send_sample(16'd100, 16'd0, 16'd1, 16'd200);
        send_sample(16'd100, 16'd1, 16'd0, 16'd200);
        send_sample(16'd1, 16'd100, 16'd0, 16'd200);
        send_sample(16'd0, 16'd1, 16'd100, 16'd200);
        send_sample(16'd5000, 16'd4000, 16'd3000, 16'd1000);
        send_sample(16'd1, 16'd0, 16'd0, 16'hFFFF);
        send_sample(16'h5555, 16'hAAAA, 16'h1234, 16'hFFFE);
        send_sample(16'hAAAA, 16'h5555, 16'hEDCB, 16'hFFFF);
        send_sample(16'd65534, 16'd65535, 16'd1, 16'd65535);

        // Random bursts; the long hold-off starts partway through.
        i = 0;
        while (i < 850) begin
            if (i >= 300 && !hold_armed) begin
                hold_armed = 1'b1;
                hold_off = 1'b1;
            end
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                send_random();
                i++;
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
        end
        i_valid <= 1'b0;

        // Drain, then let the pipeline settle.
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);

        $display("Sent %0d samples including zero-clear, clamped, tied and wrapped hues;",
                 sent);
        $display("checked %0d results under bursty input and random output stalls.",
                 sb.matched);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** rgbc_to_hsv_converter: PASSED **");
        else
            $display("** rgbc_to_hsv_converter: FAILED **");
        $finish;
    end
endmodule

// ===== files.f =====
design/rgbc_pkg.sv
design/rgbc_div.sv
design/rgbc_front.sv
design/rgbc_back.sv
design/rgbc_to_hsv_converter.sv
dv/testbench.sv
